@@ design/mbps_pkg.sv @@
// shared types and constants for the masked byte pattern search
package mbps_pkg;

  // fixed field widths
  localparam int DataW      = 8;
  localparam int PatRegW    = 64;
  localparam int CareW      = 16;
  localparam int LenRegW    = 5;
  localparam int CfgIdxW    = 2;
  localparam int OffsetOutW = 32;

  // pattern bytes that the registers can hold
  localparam int PatStoreBytes = 16;

  // parameter defaults
  localparam int PatternMaxDefault = 16;
  localparam int OffsetBitsDefault = 32;

  // register reset values
  localparam logic [PatRegW-1:0] PatLoReset = '0;
  localparam logic [PatRegW-1:0] PatHiReset = '0;
  localparam logic [CareW-1:0]   CareReset  = 16'hFFFF;
  localparam logic [LenRegW-1:0] LenReset   = 5'd1;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PAT_LO = 2'd0,
    CFG_PAT_HI = 2'd1,
    CFG_CARE   = 2'd2,
    CFG_LEN    = 2'd3
  } mbps_cfg_idx_e;

  // configuration seen by the datapath
  typedef struct packed {
    logic [PatRegW-1:0] pat_lo;
    logic [PatRegW-1:0] pat_hi;
    logic [CareW-1:0]   care;
    logic [LenRegW-1:0] len;
  } mbps_cfg_t;

  // one input transaction held in the input register
  typedef struct packed {
    logic [DataW-1:0] data;
    logic             last;
  } mbps_item_t;

endpackage

@@ design/masked_byte_pattern_search.sv @@
// top level of the masked byte pattern search
//
// Bytes of a region arrive on the input channel (in_valid_i / in_ready_o),
// one per transaction, with last_byte_i marking the region's final byte.
// At most one result per region leaves on the output channel
// (out_valid_o / out_ready_i): found_o = 1 with the start offset of the
// first match lying wholly inside the region, or found_o = 0 with offset 0
// at the last byte when no match was seen.
// Each byte lands in an input register; from there the shifted window is
// compared against the masked pattern and the result register loads once
// it can take a result. One byte per cycle is sustained while the output
// side keeps up; the single result register sets that limit. When the
// receiver stalls with a result pending, the byte in the input register
// waits and in_ready_o drops once that register is also full. Reset
// empties both registers, clears the window and position, and sets the
// configuration to an all-care, one-byte zero pattern. Registers are
// written through cfg_we_i / cfg_index_i / cfg_wdata_i; the user must
// write them only while idle, as the block does not enforce it.
module masked_byte_pattern_search
  import mbps_pkg::*;
#(
  parameter int PATTERN_MAX = PatternMaxDefault,
  parameter int OFFSET_BITS = OffsetBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [PatRegW-1:0]    cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [DataW-1:0]      data_byte_i,
  input  logic                  last_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  found_o,
  output logic [OffsetOutW-1:0] match_offset_o
);

  localparam int LenW = $clog2(PATTERN_MAX + 1);

  mbps_cfg_t                         cfg;
  mbps_item_t                        item_q;
  logic                              item_valid_q;
  logic                              advance;
  logic                              step;
  logic                              hit;
  logic                              produce;
  logic [PATTERN_MAX-1:0][DataW-1:0] win_next;
  logic [LenW-1:0]                   fill_next;
  logic [OFFSET_BITS-1:0]            pos;
  logic                              reported;
  logic [OffsetOutW-1:0]             offset;
  logic                              out_valid_q;
  logic                              found_q;
  logic [OffsetOutW-1:0]             offset_q;

  mbps_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // the held byte moves on when the result register can take a result
  assign advance    = !out_valid_q || out_ready_i;
  assign step       = item_valid_q && advance;
  assign in_ready_o = !item_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q.data <= data_byte_i;
      item_q.last <= last_byte_i;
    end
  end

  mbps_window #(
    .PATTERN_MAX (PATTERN_MAX),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (item_q),
    .hit_i       (hit),
    .win_next_o  (win_next),
    .fill_next_o (fill_next),
    .pos_o       (pos),
    .reported_o  (reported)
  );

  mbps_compare #(
    .PATTERN_MAX (PATTERN_MAX),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_compare (
    .cfg_i      (cfg),
    .win_i      (win_next),
    .fill_i     (fill_next),
    .pos_i      (pos),
    .reported_i (reported),
    .hit_o      (hit),
    .offset_o   (offset)
  );

  // a result on a match, or on a region end with nothing reported
  assign produce = step && (hit || (item_q.last && !reported));

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= produce;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && produce) begin
      found_q  <= hit;
      offset_q <= hit ? offset : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign match_offset_o = offset_q;

endmodule

@@ design/mbps_cfg_regs.sv @@
// configuration register file of the pattern search
module mbps_cfg_regs
  import mbps_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [PatRegW-1:0] cfg_wdata_i,
  output mbps_cfg_t          cfg_o
);

  mbps_cfg_t cfg_q;

  // register writes by index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pat_lo <= PatLoReset;
      cfg_q.pat_hi <= PatHiReset;
      cfg_q.care   <= CareReset;
      cfg_q.len    <= LenReset;
    end else if (cfg_we_i) begin
      case (mbps_cfg_idx_e'(cfg_index_i))
        CFG_PAT_LO: cfg_q.pat_lo <= cfg_wdata_i;
        CFG_PAT_HI: cfg_q.pat_hi <= cfg_wdata_i;
        CFG_CARE:   cfg_q.care   <= cfg_wdata_i[CareW-1:0];
        CFG_LEN:    cfg_q.len    <= cfg_wdata_i[LenRegW-1:0];
        default:    cfg_q        <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/mbps_window.sv @@
// sliding byte window, fill count, position counter and reported flag
module mbps_window
  import mbps_pkg::*;
#(
  parameter int PATTERN_MAX = PatternMaxDefault,
  parameter int OFFSET_BITS = OffsetBitsDefault,
  localparam int LenW       = $clog2(PATTERN_MAX + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              step_i,
  input  mbps_item_t                        item_i,
  input  logic                              hit_i,
  output logic [PATTERN_MAX-1:0][DataW-1:0] win_next_o,
  output logic [LenW-1:0]                   fill_next_o,
  output logic [OFFSET_BITS-1:0]            pos_o,
  output logic                              reported_o
);

  logic [PATTERN_MAX-1:0][DataW-1:0] win_q;
  logic [LenW-1:0]                   fill_q;
  logic [OFFSET_BITS-1:0]            pos_q;
  logic                              reported_q;
  logic [OFFSET_BITS-1:0]            pos_d;

  // shift the new byte in at entry 0
  always_comb begin
    win_next_o[0] = item_i.data;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      win_next_o[k] = win_q[k-1];
    end
  end

  // fill count stops at the window depth, position stops at all ones
  assign fill_next_o = (fill_q < LenW'(PATTERN_MAX)) ? fill_q + 1'b1 : fill_q;
  assign pos_d       = (pos_q != '1) ? pos_q + 1'b1 : pos_q;

  // state update, cleared at region end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q      <= '0;
      fill_q     <= '0;
      pos_q      <= '0;
      reported_q <= 1'b0;
    end else if (step_i) begin
      if (item_i.last) begin
        win_q      <= '0;
        fill_q     <= '0;
        pos_q      <= '0;
        reported_q <= 1'b0;
      end else begin
        win_q      <= win_next_o;
        fill_q     <= fill_next_o;
        pos_q      <= pos_d;
        reported_q <= reported_q | hit_i;
      end
    end
  end

  assign pos_o      = pos_q;
  assign reported_o = reported_q;

endmodule

@@ design/mbps_compare.sv @@
// masked compare of the window against the pattern and start offset
module mbps_compare
  import mbps_pkg::*;
#(
  parameter int PATTERN_MAX = PatternMaxDefault,
  parameter int OFFSET_BITS = OffsetBitsDefault,
  localparam int LenW       = $clog2(PATTERN_MAX + 1)
) (
  input  mbps_cfg_t                         cfg_i,
  input  logic [PATTERN_MAX-1:0][DataW-1:0] win_i,
  input  logic [LenW-1:0]                   fill_i,
  input  logic [OFFSET_BITS-1:0]            pos_i,
  input  logic                              reported_i,
  output logic                              hit_o,
  output logic [OffsetOutW-1:0]             offset_o
);

  localparam int IdxW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int ExtW = (LenW > LenRegW) ? LenW : LenRegW;

  logic [PATTERN_MAX-1:0][DataW-1:0] pat;
  logic [PATTERN_MAX-1:0]            care_ext;
  logic [ExtW-1:0]                   len_ext;
  logic [LenW-1:0]                   len_act;
  logic [PATTERN_MAX-1:0]            miss;
  logic [OFFSET_BITS-1:0]            off_full;

  // pattern bytes past the stored ones are wildcards
  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_pat
    if (j < 8) begin : g_lo
      assign pat[j]      = cfg_i.pat_lo[8*j +: 8];
      assign care_ext[j] = cfg_i.care[j];
    end else if (j < PatStoreBytes) begin : g_hi
      assign pat[j]      = cfg_i.pat_hi[8*(j-8) +: 8];
      assign care_ext[j] = cfg_i.care[j];
    end else begin : g_wild
      assign pat[j]      = '0;
      assign care_ext[j] = 1'b0;
    end
  end

  // clamp the length to one up to the window depth
  always_comb begin
    len_ext = ExtW'(cfg_i.len);
    if (len_ext == '0) begin
      len_ext = ExtW'(1);
    end else if (len_ext > ExtW'(PATTERN_MAX)) begin
      len_ext = ExtW'(PATTERN_MAX);
    end
    len_act = len_ext[LenW-1:0];
  end

  // window entry k faces pattern byte len-1-k
  always_comb begin
    logic [LenW-1:0] j;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      j       = len_act - 1'b1 - LenW'(k);
      miss[k] = (LenW'(k) < len_act) && care_ext[j[IdxW-1:0]] &&
                (win_i[k] != pat[j[IdxW-1:0]]);
    end
  end

  assign hit_o    = !reported_i && (fill_i >= len_act) && (miss == '0);
  assign off_full = pos_i - OFFSET_BITS'(len_act - 1'b1);

  // report the low bits of the offset, zero-extended when it is narrower
  if (OFFSET_BITS >= OffsetOutW) begin : g_trunc
    assign offset_o = off_full[OffsetOutW-1:0];
  end else begin : g_ext
    assign offset_o = OffsetOutW'(off_full);
  end

endmodule

@@ tb/tb_masked_byte_pattern_search.sv @@
// testbench for the masked byte pattern search: directed regions, random regions, backpressure
module tb_masked_byte_pattern_search;
  import mbps_pkg::*;

  localparam int WinDepth   = PatternMaxDefault;
  localparam int CycleLimit = 500000;
  localparam int PhaseItems = 190;

  typedef struct {
    logic                  found;
    logic [OffsetOutW-1:0] offset;
  } search_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]    cfg_index_i = '0;
  logic [PatRegW-1:0]    cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [DataW-1:0]      data_byte_i = '0;
  logic                  last_byte_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  found_o;
  logic [OffsetOutW-1:0] match_offset_o;

  // search model state and registers
  mbps_cfg_t             search_cfg;
  logic [DataW-1:0]      scan_win [WinDepth];
  logic [OffsetOutW-1:0] scan_pos;
  int                    scan_fill;
  logic                  scan_reported;
  search_result_t        awaited_results [$];

  int  mismatches = 0;
  int  cycle_count = 0;
  int  bytes_sent = 0;
  int  hold_cycles = 0;
  int  stall_left = 0;
  bit  send_gaps = 1'b1;
  bit  recv_gaps = 1'b1;

  masked_byte_pattern_search u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .found_o        (found_o),
    .match_offset_o (match_offset_o)
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("** masked_byte_pattern_search: FAILED **");
      $finish;
    end
  end

  // idle lengths: mostly none or short, a few long
  function automatic int pick_gap(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // clamp of the configured length to 1..16
  function automatic int active_len();
    int n;
    n = int'(search_cfg.len);
    if (n == 0) n = 1;
    if (n > WinDepth) n = WinDepth;
    return n;
  endfunction

  function automatic logic [DataW-1:0] pattern_byte(input int j);
    if (j < 8) return search_cfg.pat_lo[8*j +: 8];
    return search_cfg.pat_hi[8*(j-8) +: 8];
  endfunction

  // pattern byte 0 lines up with the oldest byte of the window span
  function automatic logic window_hit(input int alen);
    for (int j = 0; j < alen; j++) begin
      if (j < PatStoreBytes && search_cfg.care[j] && scan_win[alen-1-j] != pattern_byte(j))
        return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void clear_scan();
    for (int k = 0; k < WinDepth; k++) scan_win[k] = '0;
    scan_pos = '0;
    scan_fill = 0;
    scan_reported = 1'b0;
  endfunction

  // advance the search by one accepted byte and queue any result it causes
  function automatic void scan_byte(input logic [DataW-1:0] b, input logic last);
    int alen;
    logic [OffsetOutW-1:0] cur;
    search_result_t res;
    alen = active_len();
    cur = scan_pos;
    for (int k = WinDepth - 1; k > 0; k--) scan_win[k] = scan_win[k-1];
    scan_win[0] = b;
    if (scan_fill < WinDepth) scan_fill++;
    if (scan_pos != '1) scan_pos++;
    if (!scan_reported && scan_fill >= alen && window_hit(alen)) begin
      res.found = 1'b1;
      res.offset = cur - OffsetOutW'(alen - 1);
      awaited_results.insert(awaited_results.size(), res);
      scan_reported = 1'b1;
    end
    if (last) begin
      if (!scan_reported) begin
        res.found = 1'b0;
        res.offset = '0;
        awaited_results.insert(awaited_results.size(), res);
      end
      clear_scan();
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h", cycle_count, what, got, want);
    mismatches++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    search_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected result, found", 64'(found_o), 64'h0);
      end else begin
        want = awaited_results.pop_front();
        if (found_o !== want.found)
          report_mismatch("found", 64'(found_o), 64'(want.found));
        if (match_offset_o !== want.offset)
          report_mismatch("match_offset", 64'(match_offset_o), 64'(want.offset));
      end
    end
  end

  // receiver: random stalls plus a requested long hold-off
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      stall_left = pick_gap(recv_gaps);
    end
  end

  // one byte transaction; valid stays high when no gap follows
  task automatic send_byte(input logic [DataW-1:0] b, input logic last);
    int gap;
    gap = pick_gap(send_gaps);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    scan_byte(b, last);
    bytes_sent++;
  endtask

  // drain: input idle, all results back, then the pipeline latency
  task automatic quiesce();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input mbps_cfg_idx_e idx, input logic [PatRegW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      CFG_PAT_LO: search_cfg.pat_lo = value;
      CFG_PAT_HI: search_cfg.pat_hi = value;
      CFG_CARE:   search_cfg.care = value[CareW-1:0];
      CFG_LEN:    search_cfg.len = value[LenRegW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_registers(input logic [PatRegW-1:0] lo, input logic [PatRegW-1:0] hi,
                               input logic [PatRegW-1:0] care_word,
                               input logic [PatRegW-1:0] len_word);
    write_reg(CFG_PAT_LO, lo);
    write_reg(CFG_PAT_HI, hi);
    write_reg(CFG_CARE, care_word);
    write_reg(CFG_LEN, len_word);
    cfg_we_i <= 1'b0;
  endtask

  // reset values: one-byte all-care zero pattern
  task automatic test_reset_defaults();
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
  endtask

  // zero length acts as one, all wildcards match at once, later bytes are silent
  task automatic test_zero_length_wildcard();
    quiesce();
    set_registers(rand64(), rand64(), 64'h0, 64'h0);
    send_byte(8'hAB, 1'b0);
    send_byte(8'h5C, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // oversized length clamps to 16; full-width match ending on the last byte
  task automatic test_full_width_match();
    quiesce();
    set_registers({64{1'b1}}, 64'h0, 64'hFFFF, 64'd31);
    for (int i = 0; i < 16; i++)
      send_byte((i < 8) ? 8'hFF : 8'h00, i == 15);
  endtask

  // two-byte pattern found late in the region
  task automatic test_two_byte_match();
    quiesce();
    set_registers(64'h00FF, rand64(), 64'h3, 64'd2);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // receiver stalls long while one-byte regions keep coming
  task automatic test_backpressure();
    logic [DataW-1:0] pat;
    quiesce();
    pat = 8'($urandom());
    set_registers({56'(rand64()), pat}, rand64(), 64'hFFFF, 64'd1);
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    hold_cycles = 120;
    for (int i = 0; i < 48; i++)
      send_byte($urandom_range(0, 1) ? pat : 8'($urandom()), 1'b1);
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
  endtask

  // a byte that is noise or a pattern byte at a random place
  function automatic logic [DataW-1:0] noise_byte(input int alen);
    if ($urandom_range(0, 1)) return 8'($urandom());
    return pattern_byte($urandom_range(0, alen - 1));
  endfunction

  // regions that mostly carry the pattern, sometimes cut off by the region end
  task automatic run_search_regions(input int budget);
    logic [DataW-1:0] region [$];
    int alen, rlen, start, r, stop_at;
    alen = active_len();
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      region.delete();
      r = $urandom_range(0, 9);
      if (r < 6) rlen = $urandom_range(1, alen + 6);
      else if (r < 9) rlen = $urandom_range(1, 24);
      else rlen = $urandom_range(25, 70);
      for (int i = 0; i < rlen; i++) region.insert(region.size(), noise_byte(alen));
      if ($urandom_range(0, 9) < 7) begin
        start = $urandom_range(0, rlen - 1);
        for (int j = 0; j < alen; j++) begin
          if (start + j < rlen && search_cfg.care[j])
            region[start + j] = pattern_byte(j);
        end
      end
      for (int i = 0; i < rlen; i++) send_byte(region[i], i == rlen - 1);
    end
  endtask

  // random phases through several register settings
  task automatic test_random_search();
    logic [63:0] upper;
    for (int p = 0; p < 8; p++) begin
      quiesce();
      upper = rand64();
      case (p)
        0: set_registers(rand64(), rand64(), {upper[63:CareW], 16'hFFFF},
                         {upper[63:LenRegW], 5'd16});
        1: set_registers(64'h0, 64'h0, {upper[63:CareW], 16'hFFFF},
                         {upper[63:LenRegW], 5'd1});
        2: set_registers({64{1'b1}}, {64{1'b1}}, {upper[63:CareW], 16'h0000},
                         {upper[63:LenRegW], 5'd31});
        3: set_registers(rand64(), rand64(), rand64(), {upper[63:LenRegW], 5'd0});
        4: set_registers(rand64(), rand64(), {upper[63:CareW], 16'($urandom() & $urandom())},
                         {upper[63:LenRegW], 5'd16});
        default: set_registers(rand64(), rand64(), rand64(), rand64());
      endcase
      send_gaps = (p % 3) != 2;
      recv_gaps = (p % 4) != 3;
      run_search_regions(PhaseItems);
    end
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
  endtask

  // test sequence
  initial begin
    search_cfg = '{pat_lo: PatLoReset, pat_hi: PatHiReset, care: CareReset, len: LenReset};
    clear_scan();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_zero_length_wildcard();
    test_full_width_match();
    test_two_byte_match();
    test_backpressure();
    test_random_search();
    quiesce();
    if (mismatches == 0) begin
      $display("** masked_byte_pattern_search: PASSED **");
    end else begin
      $display("** masked_byte_pattern_search: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/mbps_pkg.sv
design/mbps_cfg_regs.sv
design/mbps_window.sv
design/mbps_compare.sv
design/masked_byte_pattern_search.sv
tb/tb_masked_byte_pattern_search.sv
